@@ rtl/lshcc_pkg.sv @@
package lshcc_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_TABLES_DEF = 16;
	localparam int HASH_BITS_DEF  = 32;

	// fixed field widths
	localparam int ROW_W    = 6;
	localparam int TBL_W    = 4;
	localparam int IN_HASH_W = 32;
	localparam int CNT_W    = 7;
	localparam int OUT_CNT_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

	// row token walking down the cell chain
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] count;
	} lshcc_tok_t;

	// storage write request broadcast to all cells
	typedef struct packed {
		logic             data_we;
		logic             query_we;
		logic [ROW_W-1:0] row;
		logic [TBL_W-1:0] tbl;
	} lshcc_wr_t;

endpackage

@@ rtl/lshcc_item_if.sv @@
interface lshcc_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic [lshcc_pkg::ROW_W-1:0]           row;
	logic [lshcc_pkg::TBL_W-1:0]           table_req;
	logic signed [lshcc_pkg::IN_HASH_W-1:0] hash_value;

	modport source (output valid, mode, row, table_req, hash_value, input ready);
	modport sink (input valid, mode, row, table_req, hash_value, output ready);
endinterface

@@ rtl/lshcc_result_if.sv @@
interface lshcc_result_if;
	logic                            valid;
	logic                            ready;
	logic [lshcc_pkg::ROW_W-1:0]     row_index;
	logic [lshcc_pkg::OUT_CNT_W-1:0] collision_count;
	logic                            is_candidate;
	logic                            last;

	modport source (output valid, row_index, collision_count, is_candidate, last,
		input ready);
	modport sink (input valid, row_index, collision_count, is_candidate, last,
		output ready);
endinterface

@@ rtl/lshcc_cfg_if.sv @@
interface lshcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lshcc_pkg::CFG_IDX_W-1:0]  index;
	logic [lshcc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/lshcc_ram.sv @@
module lshcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lshcc_cell.sv @@
module lshcc_cell #(
	parameter int MAX_ROWS  = lshcc_pkg::MAX_ROWS_DEF,
	parameter int HASH_BITS = lshcc_pkg::HASH_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   enabled,
	input  lshcc_pkg::lshcc_wr_t   wr,
	input  logic [HASH_BITS-1:0]   wr_word,
	input  lshcc_pkg::lshcc_tok_t  tok_i,
	output lshcc_pkg::lshcc_tok_t  tok_o
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	lshcc_pkg::lshcc_tok_t tok_q;
	logic [HASH_BITS-1:0]  query_q;
	logic [HASH_BITS-1:0]  rdata;
	logic                  hit;
	logic                  match;

	assign hit = ({3'b000, wr.tbl} == 7'(IDX));

	lshcc_ram #(
		.WIDTH (HASH_BITS),
		.DEPTH (MAX_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (wr.data_we & hit),
		.waddr (AW'(wr.row)),
		.wdata (wr_word),
		.re    (advance),
		.raddr (AW'(tok_i.row)),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (wr.query_we && hit) begin
			query_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_i;
		end
	end

	assign match = enabled && (rdata == query_q);

	always_comb begin
		tok_o       = tok_q;
		tok_o.count = tok_q.count + lshcc_pkg::CNT_W'(match);
	end

endmodule

@@ rtl/lsh_collision_count_candidates.sv @@
// a query-ending request starts a row walk down the table cells, through the cell
// registers into the output register: one result per cycle while the output is taken
// loads and other query words are taken whenever no query walk is busy; after a
// query-ending request no request is taken until its last result has left
// reset clears control state and sets the registers to 64 rows, 16 tables, threshold 1;
// stored hash words are unset until written
module lsh_collision_count_candidates #(
	parameter int MAX_ROWS   = lshcc_pkg::MAX_ROWS_DEF,
	parameter int MAX_TABLES = lshcc_pkg::MAX_TABLES_DEF,
	parameter int HASH_BITS  = lshcc_pkg::HASH_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	lshcc_item_if.sink     item,
	lshcc_result_if.source result,
	lshcc_cfg_if.sink      cfg
);

	logic [6:0] rows_q;
	logic [4:0] tabs_q;
	logic [4:0] thr_q;
	logic [6:0] nrows;
	logic [6:0] ntabs;

	logic                  busy_q;
	logic                  issuing_q;
	logic [6:0]            issue_q;
	logic                  advance;
	logic                  accept;
	logic                  tbl_ok;
	logic                  row_ok;
	logic                  query_end;
	logic                  issue_last;
	lshcc_pkg::lshcc_wr_t  wr;
	logic [HASH_BITS-1:0]  wr_word;
	lshcc_pkg::lshcc_tok_t tok [MAX_TABLES+1];
	lshcc_pkg::lshcc_tok_t res_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			tabs_q <= 5'd16;
			thr_q  <= 5'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lshcc_pkg::CFG_ROWS:      rows_q <= cfg.data;
				lshcc_pkg::CFG_TABLES:    tabs_q <= cfg.data[4:0];
				lshcc_pkg::CFG_THRESHOLD: thr_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == 7'd0) begin
			nrows = 7'd1;
		end else if (rows_q > 7'(MAX_ROWS)) begin
			nrows = 7'(MAX_ROWS);
		end else begin
			nrows = rows_q;
		end
		if (tabs_q == 5'd0) begin
			ntabs = 7'd1;
		end else if ({2'b00, tabs_q} > 7'(MAX_TABLES)) begin
			ntabs = 7'(MAX_TABLES);
		end else begin
			ntabs = {2'b00, tabs_q};
		end
	end

	// request decode
	assign item.ready = !busy_q;
	assign accept     = item.valid && !busy_q;
	assign tbl_ok     = ({3'b000, item.table_req} < 7'(MAX_TABLES));
	assign row_ok     = ({1'b0, item.row} < 7'(MAX_ROWS));
	assign query_end  = accept && (item.mode == lshcc_pkg::MODE_QUERY) && tbl_ok &&
		({3'b000, item.table_req} == ntabs - 7'd1);

	assign wr.data_we  = accept && (item.mode == lshcc_pkg::MODE_LOAD) && tbl_ok && row_ok;
	assign wr.query_we = accept && (item.mode == lshcc_pkg::MODE_QUERY) && tbl_ok;
	assign wr.row      = item.row;
	assign wr.tbl      = item.table_req;
	assign wr_word     = HASH_BITS'(item.hash_value);

	// chain moves whenever the output register is free or being emptied
	assign advance    = !res_q.valid || result.ready;
	assign issue_last = (issue_q == nrows - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			issue_q   <= 7'd0;
		end else begin
			if (query_end) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				issue_q   <= 7'd0;
			end else if (issuing_q && advance) begin
				issue_q <= issue_q + 7'd1;
				if (issue_last) begin
					issuing_q <= 1'b0;
				end
			end
			if (res_q.valid && result.ready && res_q.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok[0].valid = issuing_q;
	assign tok[0].last  = issue_last;
	assign tok[0].row   = lshcc_pkg::ROW_W'(issue_q);
	assign tok[0].count = '0;

	for (genvar t = 0; t < MAX_TABLES; t++) begin : g_cell
		lshcc_cell #(
			.MAX_ROWS  (MAX_ROWS),
			.HASH_BITS (HASH_BITS),
			.IDX       (t)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.enabled (7'(t) < ntabs),
			.wr      (wr),
			.wr_word (wr_word),
			.tok_i   (tok[t]),
			.tok_o   (tok[t+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (advance) begin
			res_q <= tok[MAX_TABLES];
		end
	end

	assign result.valid           = res_q.valid;
	assign result.row_index       = res_q.row;
	assign result.collision_count = lshcc_pkg::OUT_CNT_W'(res_q.count);
	assign result.is_candidate    = (res_q.count >= {2'b00, thr_q});
	assign result.last            = res_q.last;

endmodule
